/* rtl/tsl_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and codes of the tab-stop list parser and lookup.
package tsl_pkg;

   localparam int MAX_STOPS   = 32;
   localparam int COLUMN_BITS = 16;

   localparam int CHAR_W     = 8;
   localparam int COLUMN_W   = 16;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int NEXT_W     = 17;
   localparam int STOP_W     = COLUMN_BITS;
   localparam int ACC_W      = COLUMN_BITS + 1;
   localparam int COUNT_W    = $clog2(MAX_STOPS + 1);
   localparam int ADDR_W     = $clog2(MAX_STOPS);
   localparam int DIV_CNT_W  = $clog2(STOP_W);
   localparam int PROD_W     = 2 * STOP_W + 1;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic [ACC_W-1:0]  COL_MAX  = {1'b0, {STOP_W{1'b1}}};
   localparam logic [ACC_W-1:0]  ACC_SAT  = {1'b1, {STOP_W{1'b0}}};
   localparam logic [NEXT_W-1:0] NEXT_MAX = {NEXT_W{1'b1}};

   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [ACC_W+3:0]  RADIX    = 10;

   typedef enum logic [OP_W-1:0] {
      OP_CHAR,
      OP_END,
      OP_QUERY,
      OP_NONE
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK,
      STAT_ERR,
      STAT_NOSET
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_MUL,
      ST_ADJ,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

/* rtl/tab_stop_list_parse_and_lookup.sv */
`timescale 1ns / 1ps
// Tab-stop list spec parser with next-stop lookup over a one-port stop memory.
// Spec bytes, end of spec and queries without a setting are answered from the execute state;
//   interval queries go through a 16-step restoring divider, one multiply and one add, and
//   skip them at column zero; list queries scan the stop memory up to the first stop past
//   the column. One item at a time: a new item is taken only once the last result is loaded.
// Reset: synchronous, active high; clears parse state and setting, empties the result
//   register. The stop memory is not cleared: only written entries are ever read.
module tab_stop_list_parse_and_lookup (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [7:0] spec_char, [23:8] column
   input  logic [tsl_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [tsl_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] status, [18:2] next_stop, [19] is_interval, [23:20] zero
   output logic [tsl_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tsl_pkg::*;

   // Control state
   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic [COLUMN_W-1:0]  col_ff, col_in;

   // Parse and setting state
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [STOP_W-1:0]    intv_ff, intv_in;
   logic [STOP_W-1:0]    last_stop_ff, last_stop_in;
   logic [ACC_W-1:0]     accum_ff, accum_in;
   logic                 in_number_ff, in_number_in;
   logic                 err_ff, err_in;
   logic                 valid_ff, valid_in;

   // Divider, multiplier and scan
   logic [STOP_W-1:0]    quo_ff, quo_in;
   logic [STOP_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [NEXT_W-1:0]    next_ff, next_in;
   logic [COUNT_W-1:0]   idx_ff, idx_in;
   logic                 chk_ff, chk_in;

   // Stop memory
   logic [STOP_W-1:0]    stop_store [MAX_STOPS];
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [STOP_W-1:0]    mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [STOP_W-1:0]    rd_data_ff;

   // Result register
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff, res_status;
   logic [NEXT_W-1:0]    rsp_next_ff, res_next;
   logic                 rsp_intv_ff, res_intv;
   logic                 rsp_load;
   logic                 out_free;

   // Helpers
   logic                 accept;
   logic                 is_sep;
   logic                 is_digit;
   logic [ACC_W+3:0]     acc10;
   logic [COUNT_W-1:0]   cnt_base;
   logic                 fin_bad;
   logic                 fin_ok;
   logic                 err_fin;
   logic [COUNT_W-1:0]   cnt_fin;
   logic [STOP_W-1:0]    first_stop;
   logic [STOP_W:0]      rem_sh;
   logic [PROD_W-1:0]    prod_inc;
   logic                 scan_hit;
   logic                 scan_end;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign is_sep   = (char_ff == CH_COMMA) || (char_ff == CH_SPACE) || (char_ff == CH_TAB);
   assign is_digit = (char_ff >= CH_ZERO) && (char_ff <= CH_NINE);
   assign acc10    = (ACC_W + 4)'(accum_ff) * RADIX + (ACC_W + 4)'(char_ff - CH_ZERO);

   // A new spec byte drops a committed setting before it is parsed
   assign cnt_base = (op_ff == OP_CHAR && valid_ff) ? '0 : count_ff;
   assign fin_bad  = (accum_ff == '0) || (accum_ff > COL_MAX)
                  || (cnt_base != '0 && ACC_W'(last_stop_ff) >= accum_ff)
                  || (cnt_base >= COUNT_W'(MAX_STOPS));
   assign fin_ok   = in_number_ff && !err_ff && !fin_bad;
   assign err_fin  = err_ff || (in_number_ff && fin_bad);
   assign cnt_fin  = fin_ok ? count_ff + COUNT_W'(1) : count_ff;
   assign first_stop = fin_ok ? accum_ff[STOP_W-1:0] : last_stop_ff;

   assign rem_sh   = {rem_ff, quo_ff[STOP_W-1]};
   assign prod_inc = prod_ff + PROD_W'(1);

   assign scan_hit = chk_ff && (32'(rd_data_ff) > 32'(col_ff));
   assign scan_end = chk_ff && !scan_hit && (idx_ff == count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (op_ff == OP_QUERY && valid_ff) begin
               if (intv_ff == '0)       state_in = ST_SCAN;
               else if (col_ff == '0)   state_in = ST_FINISH;
               else                     state_in = ST_DIV;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(STOP_W - 1)) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_ADJ;
         ST_ADJ:  state_in = ST_FINISH;
         ST_SCAN: begin
            if (scan_hit || scan_end) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs and result load
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_EXEC:   rsp_load   = out_free && !(op_ff == OP_QUERY && valid_ff);
         ST_FINISH: rsp_load   = out_free;
         default: begin
            req_tready = 1'b0;
            rsp_load   = 1'b0;
         end
      endcase
   end

   // Datapath
   always_comb begin
      op_in        = op_ff;
      char_in      = char_ff;
      col_in       = col_ff;
      count_in     = count_ff;
      intv_in      = intv_ff;
      last_stop_in = last_stop_ff;
      accum_in     = accum_ff;
      in_number_in = in_number_ff;
      err_in       = err_ff;
      valid_in     = valid_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      prod_in      = prod_ff;
      next_in      = next_ff;
      idx_in       = idx_ff;
      chk_in       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cnt_base[ADDR_W-1:0];
      mem_wdata    = accum_ff[STOP_W-1:0];
      mem_re       = 1'b0;
      mem_raddr    = idx_ff[ADDR_W-1:0];
      res_status   = STAT_OK;
      res_next     = '0;
      res_intv     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = op_type'(req_tuser);
               char_in = req_tdata[CHAR_W-1:0];
               col_in  = req_tdata[CHAR_W +: COLUMN_W];
            end
         end

         ST_EXEC: begin
            unique case (op_ff)
               OP_CHAR: begin
                  if (out_free) begin
                     if (valid_ff) begin
                        valid_in = 1'b0;
                        count_in = '0;
                        intv_in  = '0;
                     end
                     if (!err_ff) begin
                        if (is_sep) begin
                           if (in_number_ff) begin
                              if (fin_bad) begin
                                 err_in = 1'b1;
                              end else begin
                                 mem_we       = 1'b1;
                                 last_stop_in = accum_ff[STOP_W-1:0];
                                 count_in     = cnt_base + COUNT_W'(1);
                              end
                              in_number_in = 1'b0;
                              accum_in     = '0;
                           end
                        end else if (is_digit) begin
                           in_number_in = 1'b1;
                           accum_in     = (acc10 > (ACC_W + 4)'(COL_MAX)) ?
                                          ACC_SAT : acc10[ACC_W-1:0];
                        end else begin
                           err_in = 1'b1;
                        end
                     end
                  end
                  res_status = err_in ? STAT_ERR : STAT_OK;
               end

               OP_END: begin
                  if (out_free) begin
                     // Close any open token, then commit or drop the setting
                     if (fin_ok) begin
                        mem_we       = 1'b1;
                        last_stop_in = accum_ff[STOP_W-1:0];
                     end
                     if (err_fin || cnt_fin == '0) begin
                        count_in = '0;
                        intv_in  = '0;
                        valid_in = 1'b0;
                     end else begin
                        count_in = cnt_fin;
                        valid_in = 1'b1;
                        intv_in  = (cnt_fin == COUNT_W'(1)) ? first_stop : '0;
                     end
                     in_number_in = 1'b0;
                     accum_in     = '0;
                     err_in       = 1'b0;
                  end
                  res_status = (err_fin || cnt_fin == '0) ? STAT_ERR : STAT_OK;
                  res_intv   = !(err_fin || cnt_fin == '0) && (cnt_fin == COUNT_W'(1))
                               && (first_stop != '0);
               end

               OP_QUERY: begin
                  res_status = STAT_NOSET;
                  if (valid_ff) begin
                     if (intv_ff == '0) begin
                        idx_in = '0;
                     end else if (col_ff == '0) begin
                        next_in = NEXT_W'(1);
                     end else begin
                        quo_in     = STOP_W'(col_ff - COLUMN_W'(1));
                        rem_in     = '0;
                        div_cnt_in = '0;
                     end
                  end
               end

               OP_NONE: res_status = STAT_OK;

               default: res_status = STAT_OK;
            endcase
         end

         ST_DIV: begin
            // One restoring step: quotient bits shift in where dividend bits leave
            if (rem_sh >= {1'b0, intv_ff}) begin
               rem_in = STOP_W'(rem_sh - {1'b0, intv_ff});
               quo_in = {quo_ff[STOP_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[STOP_W-1:0];
               quo_in = {quo_ff[STOP_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end

         ST_MUL: begin
            prod_in = PROD_W'({1'b0, quo_ff} + (STOP_W + 1)'(1)) * PROD_W'(intv_ff);
         end

         ST_ADJ: begin
            next_in = (prod_inc > PROD_W'(NEXT_MAX)) ? NEXT_MAX : prod_inc[NEXT_W-1:0];
         end

         ST_SCAN: begin
            // Issue one read a cycle; compare the entry read the cycle before
            if (idx_ff < count_ff) begin
               mem_re = 1'b1;
               idx_in = idx_ff + COUNT_W'(1);
               chk_in = 1'b1;
            end
            if (scan_hit) begin
               next_in = (32'(rd_data_ff) > 32'(NEXT_MAX)) ? NEXT_MAX : NEXT_W'(rd_data_ff);
            end else if (scan_end) begin
               next_in = '0;
            end
         end

         ST_FINISH: begin
            res_status = STAT_OK;
            res_next   = next_ff;
            res_intv   = (intv_ff != '0);
         end

         default: res_status = STAT_OK;
      endcase
   end

   // Stop memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stop_store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= stop_store[mem_raddr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         intv_ff      <= '0;
         accum_ff     <= '0;
         in_number_ff <= 1'b0;
         err_ff       <= 1'b0;
         valid_ff     <= 1'b0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         intv_ff      <= intv_in;
         accum_ff     <= accum_in;
         in_number_ff <= in_number_in;
         err_ff       <= err_in;
         valid_ff     <= valid_in;
         chk_ff       <= chk_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      char_ff      <= char_in;
      col_ff       <= col_in;
      last_stop_ff <= last_stop_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      prod_ff      <= prod_in;
      next_ff      <= next_in;
      idx_ff       <= idx_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status;
         rsp_next_ff   <= res_next;
         rsp_intv_ff   <= res_intv;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_intv_ff, rsp_next_ff, rsp_status_ff});

endmodule

/* rtl/tsl_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the tab-stop list block and its bind.
module tsl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tsl_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tsl_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One item at a time: no acceptance in the cycle after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   // No setting means no stop and no interval flag
   a_noset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[STATUS_W-1:0] == STAT_NOSET
      |-> rsp_tdata[STATUS_W +: NEXT_W] == '0 && !rsp_tdata[STATUS_W + NEXT_W])
      else $error("no-setting answer carries data");

   // Interval flag only with a good status
   a_intv_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[STATUS_W + NEXT_W] |-> rsp_tdata[STATUS_W-1:0] == STAT_OK)
      else $error("interval flag with error status");

endmodule

bind tab_stop_list_parse_and_lookup tsl_checker u_tsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
